[src/kmp_pkg.sv]
// Shared types, codes and defaults for the streaming KMP matcher.
`timescale 1ns / 1ps

package kmp_pkg;

   // Default sizes
   localparam int MAX_PATTERN_DEF = 64;
   localparam int POS_WIDTH_DEF   = 32;

   // Action codes carried in the request word
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_TEXT   = 2'd2;

   // Status codes carried in the response word
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_MATCH = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] match_start;
   } rsp_word_type;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_HIT,
      S_DONE
   } state_type;

   // What the datapath commits when the word finishes
   typedef enum logic [2:0] {
      OP_NOP,
      OP_CLEAR,
      OP_APPEND,
      OP_TEXT,
      OP_EMPTY_TEXT
   } op_type;

   // Controller to datapath
   typedef struct packed {
      logic       start;
      logic       step;
      logic       hit_load;
      logic       commit;
      op_type     op;
      logic [1:0] status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic full;
      logic len_zero;
      logic walk_more;
      logic at_last;
      logic rsp_free;
   } sts_type;

endpackage

[src/kmp_ctrl.sv]
// Controller state machine for the streaming KMP matcher.
`timescale 1ns / 1ps

module kmp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_action,
   output logic             req_ready,
   input  kmp_pkg::sts_type sts,
   output kmp_pkg::cmd_type cmd
);

   kmp_pkg::state_type state_ff, state_in;
   kmp_pkg::op_type    op_ff, op_in, op_sel;
   logic [1:0]         status_ff, status_in, status_sel;

   // Decode the incoming action against the pattern fill level
   always_comb begin
      op_sel     = kmp_pkg::OP_NOP;
      status_sel = kmp_pkg::ST_OK;
      case (req_action)
         kmp_pkg::ACT_CLEAR: begin
            op_sel = kmp_pkg::OP_CLEAR;
         end
         kmp_pkg::ACT_APPEND: begin
            if (sts.full) begin
               status_sel = kmp_pkg::ST_FULL;
            end else begin
               op_sel = kmp_pkg::OP_APPEND;
            end
         end
         kmp_pkg::ACT_TEXT: begin
            if (sts.len_zero) begin
               op_sel     = kmp_pkg::OP_EMPTY_TEXT;
               status_sel = kmp_pkg::ST_EMPTY;
            end else begin
               op_sel = kmp_pkg::OP_TEXT;
            end
         end
         default: begin
            op_sel = kmp_pkg::OP_NOP;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= kmp_pkg::S_IDLE;
         op_ff     <= kmp_pkg::OP_NOP;
         status_ff <= kmp_pkg::ST_OK;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         status_ff <= status_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      req_ready    = 1'b0;
      cmd.start    = 1'b0;
      cmd.step     = 1'b0;
      cmd.hit_load = 1'b0;
      cmd.commit   = 1'b0;
      cmd.op       = op_ff;
      cmd.status   = status_ff;
      case (state_ff)
         kmp_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.op    = op_sel;
            if (req_valid) begin
               cmd.start = 1'b1;
               op_in     = op_sel;
               status_in = status_sel;
               // first pattern byte needs no link walk
               if ((op_sel == kmp_pkg::OP_TEXT) ||
                   (op_sel == kmp_pkg::OP_APPEND && !sts.len_zero)) begin
                  state_in = kmp_pkg::S_WALK;
               end else begin
                  state_in = kmp_pkg::S_DONE;
               end
            end
         end
         kmp_pkg::S_WALK: begin
            cmd.step = 1'b1;
            if (!sts.walk_more) begin
               if (op_ff == kmp_pkg::OP_TEXT && sts.at_last) begin
                  state_in = kmp_pkg::S_HIT;
               end else begin
                  state_in = kmp_pkg::S_DONE;
               end
            end
         end
         kmp_pkg::S_HIT: begin
            // fall back through the link of the last pattern byte
            cmd.hit_load = 1'b1;
            state_in     = kmp_pkg::S_DONE;
         end
         kmp_pkg::S_DONE: begin
            if (sts.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = kmp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = kmp_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[src/kmp_datapath.sv]
// Datapath of the streaming KMP matcher: pattern and link memories, walk, result register.
`timescale 1ns / 1ps

module kmp_datapath #(
   parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF,
   parameter int POS_WIDTH   = kmp_pkg::POS_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_byte,
   input  kmp_pkg::cmd_type      cmd,
   output kmp_pkg::sts_type      sts,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kmp_pkg::rsp_word_type rsp_word
);

   localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LW = $clog2(MAX_PATTERN + 1);
   localparam int DW0 = (POS_WIDTH > LW) ? POS_WIDTH : LW;
   localparam int DW = (DW0 > 32) ? DW0 : 32;
   localparam logic [DW-1:0] POS_MASK = (DW'(1) << POS_WIDTH) - DW'(1);

   // Pattern bytes and failure links
   logic [7:0]    pat_mem  [MAX_PATTERN];
   logic [IW-1:0] fail_mem [MAX_PATTERN];

   // Control state
   logic [LW-1:0]        len_ff, len_in;
   logic [IW-1:0]        build_ff, build_in;
   logic [IW-1:0]        match_ff, match_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [LW-1:0]         k_ff, k_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  hit_ff, hit_in;
   logic [7:0]            prd_ff;
   logic [IW-1:0]         frd_ff;
   kmp_pkg::rsp_word_type rsp_ff, rsp_in;

   logic          eq;
   logic [LW-1:0] k_in_m1;
   logic [IW-1:0] link;
   logic [DW-1:0] start_full;

   assign eq      = (byte_ff == prd_ff);
   assign k_in_m1 = k_in - LW'(1);
   // without a match the walk ends at zero, so the new prefix is the link
   assign link    = k_ff[IW-1:0];

   // Status toward the controller
   always_comb begin
      sts.full      = (len_ff == LW'(MAX_PATTERN));
      sts.len_zero  = (len_ff == '0);
      sts.walk_more = (k_ff != '0) && !eq;
      sts.at_last   = eq && (k_ff == len_ff - LW'(1));
      sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // Walk register: start prefix, failure steps, fall back after a hit
   always_comb begin
      k_in    = k_ff;
      byte_in = byte_ff;
      hit_in  = hit_ff;
      if (cmd.start) begin
         byte_in = req_byte;
         hit_in  = 1'b0;
         if (cmd.op == kmp_pkg::OP_TEXT) begin
            k_in = LW'(match_ff);
         end else begin
            k_in = LW'(build_ff);
         end
      end else if (cmd.step) begin
         if ((k_ff != '0) && !eq) begin
            k_in = LW'(frd_ff);
         end else if (eq) begin
            k_in = k_ff + LW'(1);
         end
      end else if (cmd.hit_load) begin
         k_in   = LW'(frd_ff);
         hit_in = 1'b1;
      end
   end

   // Match start modulo the position width
   assign start_full = (DW'(pos_ff) - DW'(len_ff) + DW'(1)) & POS_MASK;

   // Commit of the finished word
   always_comb begin
      len_in       = len_ff;
      build_in     = build_ff;
      match_in     = match_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = cmd.status;
         rsp_in.match_start = '0;
         case (cmd.op)
            kmp_pkg::OP_CLEAR: begin
               len_in   = '0;
               build_in = '0;
               match_in = '0;
               pos_in   = '0;
            end
            kmp_pkg::OP_APPEND: begin
               len_in = len_ff + LW'(1);
               if (len_ff != '0) begin
                  build_in = link;
               end
            end
            kmp_pkg::OP_TEXT: begin
               match_in = k_ff[IW-1:0];
               pos_in   = pos_ff + POS_WIDTH'(1);
               if (hit_ff) begin
                  rsp_in.status      = kmp_pkg::ST_MATCH;
                  rsp_in.match_start = start_full[31:0];
               end else begin
                  rsp_in.status = kmp_pkg::ST_OK;
               end
            end
            kmp_pkg::OP_EMPTY_TEXT: begin
               pos_in = pos_ff + POS_WIDTH'(1);
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         build_ff     <= '0;
         match_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         build_ff     <= build_in;
         match_ff     <= match_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      byte_ff <= byte_in;
      hit_ff  <= hit_in;
      rsp_ff  <= rsp_in;
   end

   // Memories: read data follows the walk register, write on append commit
   always_ff @(posedge clock) begin
      prd_ff <= pat_mem[k_in[IW-1:0]];
      frd_ff <= fail_mem[k_in_m1[IW-1:0]];
      if (cmd.commit && cmd.op == kmp_pkg::OP_APPEND) begin
         pat_mem[len_ff[IW-1:0]] <= byte_ff;
         if (len_ff == '0) begin
            fail_mem[len_ff[IW-1:0]] <= '0;
         end else begin
            fail_mem[len_ff[IW-1:0]] <= link;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

[src/kmp_stream_matcher.sv]
// Top level of the streaming KMP matcher.
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+--------------------------------
//   req     | in        | req_valid/req_ready | action, data_byte
//   rsp     | out       | rsp_valid/rsp_ready | status, match_start
//
// Clear, ignored append and unknown action go from idle straight to the commit
// state, as do a first pattern byte and text into an empty pattern.
// Other appends and text bytes pass through the walk state, which follows the
// failure links one link per cycle through the link memory read port; a match
// adds the hit state for the fall-back link.
// The result register lets the next word enter while a result waits.
// Reset is synchronous, clears lengths, prefixes and position; memories are
// not cleared. A stalled rsp holds the block before its next commit.
`timescale 1ns / 1ps

module kmp_stream_matcher #(
   parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF,
   parameter int POS_WIDTH   = kmp_pkg::POS_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kmp_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kmp_pkg::rsp_word_type rsp_word
);

   kmp_pkg::cmd_type cmd;
   kmp_pkg::sts_type sts;

   // Sequencer
   kmp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_word.action),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Stores, walk and result register
   kmp_datapath #(
      .MAX_PATTERN (MAX_PATTERN),
      .POS_WIDTH   (POS_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_byte  (req_word.data_byte),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

[src/kmp_checker.sv]
// Port-level checks for the streaming KMP matcher, bound to the top level.
`timescale 1ns / 1ps

module kmp_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input kmp_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input kmp_pkg::rsp_word_type rsp_word
);

   logic [1:0] pending_ff, pending_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Words accepted but not yet answered
   always_comb begin
      pending_in = pending_ff + 2'(req_fire) - 2'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A waiting request word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_word))
      else $error("request changed while waiting");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result changed while stalled");

   // Every result answers one accepted word
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without an accepted word");

   // At most one word in work and one waiting
   a_pending_max: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many words outstanding");

   // Start position only goes with a match
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != kmp_pkg::ST_MATCH |-> rsp_word.match_start == 32'd0)
      else $error("match start set without a match");

endmodule

bind kmp_stream_matcher kmp_checker u_kmp_checker (.*);

[tb/tb_kmp_stream_matcher.sv]
// Self-checking testbench for the streaming KMP matcher: directed and random words.
`timescale 1ns / 1ps

module tb_kmp_stream_matcher;

   localparam int          MAX_PAT     = kmp_pkg::MAX_PATTERN_DEF;
   localparam logic [1:0]  ACT_UNUSED  = 2'd3;
   localparam int          TOTAL_WORDS = 1850;
   localparam int          DRAIN_WAIT  = 200;
   localparam longint      CYCLE_LIMIT = 1000000;

   // Tracks pattern, failure links and match progress; predicts every result word
   class match_scoreboard;
      logic [7:0]            pat_bytes [MAX_PAT];
      logic [5:0]            fail_links [MAX_PAT];
      int unsigned           pat_len;
      int unsigned           build_len;
      int unsigned           match_len;
      logic [31:0]           text_pos;
      kmp_pkg::rsp_word_type expected_results [$];
      int unsigned           error_count;

      function new();
         foreach (pat_bytes[i]) begin
            pat_bytes[i]  = '0;
            fail_links[i] = '0;
         end
         pat_len     = 0;
         build_len   = 0;
         match_len   = 0;
         text_pos    = '0;
         error_count = 0;
      endfunction

      // One step of the failure-table build loop
      function void extend_pattern(logic [7:0] b);
         int unsigned pos;
         int unsigned k;
         logic [5:0]  link;
         pos  = pat_len;
         k    = build_len;
         link = '0;
         pat_bytes[pos] = b;
         if (pos > 0) begin
            while (k > 0 && b != pat_bytes[k])
               k = fail_links[k - 1];
            if (b == pat_bytes[k]) begin
               k    = k + 1;
               link = 6'(k);
            end
            build_len = k;
         end
         fail_links[pos] = link;
         pat_len = pos + 1;
      endfunction

      // Advance the match state by one text byte; returns 1 on a full match
      function bit scan_byte(logic [7:0] b);
         int unsigned k;
         bit          hit;
         k   = match_len;
         hit = 1'b0;
         while (k > 0 && b != pat_bytes[k])
            k = fail_links[k - 1];
         if (b == pat_bytes[k]) begin
            if (k == pat_len - 1) begin
               hit = 1'b1;
               k   = fail_links[k];
            end else begin
               k = k + 1;
            end
         end
         match_len = k;
         return hit;
      endfunction

      function void take_request(kmp_pkg::req_word_type w);
         kmp_pkg::rsp_word_type r;
         r.status      = kmp_pkg::ST_OK;
         r.match_start = '0;
         case (w.action)
            kmp_pkg::ACT_CLEAR: begin
               pat_len   = 0;
               build_len = 0;
               match_len = 0;
               text_pos  = '0;
            end
            kmp_pkg::ACT_APPEND: begin
               if (pat_len >= MAX_PAT)
                  r.status = kmp_pkg::ST_FULL;
               else
                  extend_pattern(w.data_byte);
            end
            kmp_pkg::ACT_TEXT: begin
               if (pat_len == 0) begin
                  r.status = kmp_pkg::ST_EMPTY;
               end else if (scan_byte(w.data_byte)) begin
                  r.status      = kmp_pkg::ST_MATCH;
                  r.match_start = text_pos - 32'(pat_len - 1);
               end
               text_pos = text_pos + 32'd1;
            end
            default: ;
         endcase
         expected_results = {expected_results, r};
      endfunction

      function void check_result(kmp_pkg::rsp_word_type got);
         kmp_pkg::rsp_word_type want;
         if (expected_results.size() == 0) begin
            $error("unexpected result word: status %0d match_start %0d",
                   got.status, got.match_start);
            error_count++;
            return;
         end
         want = expected_results.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
         end
         if (got.match_start !== want.match_start) begin
            $error("match_start: expected %0d, got %0d", want.match_start, got.match_start);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   kmp_pkg::req_word_type req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   kmp_pkg::rsp_word_type rsp_word;

   match_scoreboard sb;
   int     sent_count     = 0;
   int     send_idle_pct  = 0;
   int     recv_stall_pct = 0;
   longint cycle_count    = 0;

   kmp_stream_matcher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Receiver: random back-pressure, updated on the falling edge
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Result words are checked at the rising edge they are taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_word);
   end

   // Idle pattern follows run progress: none, sender, receiver, both
   task automatic set_phase();
      int phase;
      phase = (sent_count * 4) / TOTAL_WORDS;
      case (phase)
         0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
         default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
   endtask

   // Drive one request word; returns at the falling edge after it is taken
   task automatic send_word(logic [1:0] act, logic [7:0] data);
      kmp_pkg::req_word_type w;
      w.action    = act;
      w.data_byte = data;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_word  = w;
      do
         @(posedge clock);
      while (!req_ready);
      sb.take_request(w);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic run_directed();
      // text before any pattern, then an unknown action
      send_word(kmp_pkg::ACT_TEXT, 8'h00);
      send_word(ACT_UNUSED, 8'hFF);
      // pattern built from the extreme byte values
      send_word(kmp_pkg::ACT_APPEND, 8'h00);
      send_word(kmp_pkg::ACT_APPEND, 8'hFF);
      send_word(kmp_pkg::ACT_APPEND, 8'h00);
      send_word(kmp_pkg::ACT_TEXT, 8'h00);
      send_word(kmp_pkg::ACT_TEXT, 8'hFF);
      send_word(kmp_pkg::ACT_TEXT, 8'h00);
      send_word(kmp_pkg::ACT_TEXT, 8'hFF);
      send_word(kmp_pkg::ACT_TEXT, 8'h00);
      // grow the pattern in the middle of the text
      send_word(kmp_pkg::ACT_APPEND, 8'hFF);
      send_word(kmp_pkg::ACT_TEXT, 8'hFF);
      send_word(kmp_pkg::ACT_TEXT, 8'h00);
      send_word(kmp_pkg::ACT_TEXT, 8'hFF);
      // overlapping matches after a clear
      send_word(kmp_pkg::ACT_CLEAR, 8'h5A);
      send_word(kmp_pkg::ACT_APPEND, 8'h61);
      send_word(kmp_pkg::ACT_APPEND, 8'h61);
      send_word(kmp_pkg::ACT_TEXT, 8'h61);
      send_word(kmp_pkg::ACT_TEXT, 8'h61);
      send_word(kmp_pkg::ACT_TEXT, 8'h61);
      send_word(kmp_pkg::ACT_TEXT, 8'h61);
      send_word(kmp_pkg::ACT_TEXT, 8'h62);
      // empty again
      send_word(kmp_pkg::ACT_CLEAR, 8'hA5);
      send_word(kmp_pkg::ACT_TEXT, 8'hFF);
   endtask

   // One random session: mostly pattern-then-text over a small alphabet
   task automatic run_session();
      logic [7:0] alpha [4];
      int asize;
      int plen;
      int tlen;
      int roll;
      roll  = $urandom_range(0, 99);
      asize = $urandom_range(1, 4);
      foreach (alpha[i]) alpha[i] = 8'($urandom);
      if (roll < 85) begin
         if ($urandom_range(0, 9) != 0)
            send_word(kmp_pkg::ACT_CLEAR, 8'($urandom));
         if ($urandom_range(0, 19) == 0)
            send_word(kmp_pkg::ACT_TEXT, alpha[0]);
         if ($urandom_range(0, 19) == 0)
            plen = MAX_PAT + $urandom_range(1, 3);
         else
            plen = $urandom_range(1, 8);
         repeat (plen) send_word(kmp_pkg::ACT_APPEND, alpha[$urandom_range(0, asize - 1)]);
         tlen = $urandom_range(5, 40);
         repeat (tlen) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
               send_word(kmp_pkg::ACT_APPEND, alpha[$urandom_range(0, asize - 1)]);
            else if (roll < 4)
               send_word(ACT_UNUSED, 8'($urandom));
            else
               send_word(kmp_pkg::ACT_TEXT, alpha[$urandom_range(0, asize - 1)]);
         end
      end else begin
         // noise: any action, any byte
         repeat ($urandom_range(1, 10)) send_word(2'($urandom), 8'($urandom));
      end
   endtask

   // Watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_phase();
      run_directed();
      while (sent_count < TOTAL_WORDS) begin
         set_phase();
         run_session();
      end
      req_valid = 1'b0;

      // drain outstanding results, then watch for strays
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sb.error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[filelist.f]
src/kmp_pkg.sv
src/kmp_ctrl.sv
src/kmp_datapath.sv
src/kmp_stream_matcher.sv
src/kmp_checker.sv
tb/tb_kmp_stream_matcher.sv
